@@ design/rcd_pkg.sv @@
// shared types and constants for the rc drive mode controller
`default_nettype none

package rcd_pkg;

  // fixed field widths
  localparam int PULSE_W    = 15;
  localparam int STEP_W     = 10;
  localparam int ELAPSED_W  = 17;
  localparam int CMD_W      = 8;
  localparam int PWM_W      = 8;
  localparam int DB_W       = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // datapath widths, sized for raw channels of up to 16 bits
  localparam int OPW = 18;
  localparam int QW  = 28;
  localparam int SW  = QW + 1;

  // channel mapping constants
  localparam int LINK_MIN      = 100;
  localparam int RAW_CENTER    = 1000;
  localparam int CHAN_OFFSET   = 100;
  localparam int MAG_SCALE     = 127;
  localparam int SWITCH_ON_MIN = 50;
  localparam int CMD_LIMIT     = 127;

  // intake pulse thresholds in microseconds
  localparam int PULSE_LOW_MIN  = 1200;
  localparam int PULSE_HIGH_MIN = 1600;
  localparam int PULSE_MAX      = 25000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DRIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CMD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTAKE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTAKE_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd5;

  typedef enum logic [1:0] {
    DIV_5   = 2'd0,
    DIV_10  = 2'd1,
    DIV_100 = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     start;
    div_sel_t dsel;
  } mdu_req_t;

endpackage

`default_nettype wire

@@ design/rc_drive_mode_controller_top.sv @@
// top level: tick sequencer, mode and auto sequence state, held drive outputs
//
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  steer, forward, throttle, switch, intake pulse, step
// out_     output     out_valid / out_stall right, left, intake pwm, auto active, link ok
// cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// each item makes seven passes through the shared multiply/divide unit
// between its accept and its commit
// the commit waits while a previous result is still held on a stalled output
// synchronous active-low reset restores configuration defaults and clears all holds
`default_nettype none

module rc_drive_mode_controller_top
  import rcd_pkg::*;
#(
  parameter int RAW_WIDTH = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [RAW_WIDTH-1:0]   in_steer_raw,
  input  wire logic [RAW_WIDTH-1:0]   in_forward_raw,
  input  wire logic [RAW_WIDTH-1:0]   in_throttle_raw,
  input  wire logic [RAW_WIDTH-1:0]   in_switch_raw,
  input  wire logic [PULSE_W-1:0]     in_intake_pulse_us,
  input  wire logic [STEP_W-1:0]      in_step_ms,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [CMD_W-1:0]     out_right_cmd,
  output logic signed [CMD_W-1:0]     out_left_cmd,
  output logic [PWM_W-1:0]            out_intake_pwm,
  output logic                        out_auto_active,
  output logic                        out_link_ok,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [2:0] OP_STEER   = 3'd0;
  localparam logic [2:0] OP_FWD     = 3'd1;
  localparam logic [2:0] OP_THR     = 3'd2;
  localparam logic [2:0] OP_SW      = 3'd3;
  localparam logic [2:0] OP_MAG     = 3'd4;
  localparam logic [2:0] OP_FWDMIX  = 3'd5;
  localparam logic [2:0] OP_TURN    = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_COMMIT = 4'b1000
  } seq_state_t;

  typedef enum logic [2:0] {
    STG_IDLE  = 3'b001,
    STG_DRIVE = 3'b010,
    STG_DONE  = 3'b100
  } stage_t;

  // configuration
  logic [ELAPSED_W-1:0]    timeout_r;
  logic [ELAPSED_W-1:0]    drive_ms_r;
  logic signed [CMD_W-1:0] drive_cmd_r;
  logic [PWM_W-1:0]        intake_low_r;
  logic [PWM_W-1:0]        intake_high_r;
  logic [DB_W-1:0]         deadband_r;

  // sequencer
  seq_state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  // captured item
  logic [RAW_WIDTH-1:0] steer_r, fwd_raw_r, thr_r, sw_r;
  logic [PULSE_W-1:0]   pulse_r;
  logic [STEP_W-1:0]    step_r;

  // mapped values
  logic signed [OPW-1:0] steer_q_r, c2_r, c3_r, mag_r;
  logic signed [QW-1:0]  fwd_r, turn_r;
  logic                  sw_on_r;

  // tick state
  logic                    mode_r, mode_nxt;
  stage_t                  stage_r, stage_nxt;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic signed [CMD_W-1:0] right_r, right_nxt;
  logic signed [CMD_W-1:0] left_r, left_nxt;
  logic [PWM_W-1:0]        intake_r, intake_nxt;
  logic                    link_r, link_nxt;

  mdu_req_t              md_req;
  logic signed [OPW-1:0] md_a, md_b;
  logic                  md_done;
  logic signed [QW-1:0]  md_q;

  logic                    accept, commit;
  logic [ELAPSED_W:0]      el_sum;
  logic [ELAPSED_W-1:0]    el;
  logic                    link;
  logic                    manual, auto_go, auto_branch;
  logic signed [SW-1:0]    left_sum, right_sum;
  logic signed [CMD_W-1:0] left_shaped, right_shaped;
  logic signed [CMD_W-1:0] drive_clamped;
  logic [PWM_W-1:0]        intake_sel;

  function automatic logic signed [OPW-1:0] centered(input logic [RAW_WIDTH-1:0] raw);
    centered = signed'(OPW'(raw)) - OPW'(RAW_CENTER);
  endfunction

  assign accept = in_valid && !in_stall;
  assign commit = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);

  // operand selection for the shared unit
  always_comb begin
    md_req.start = (state_r == S_ISSUE);
    case (op_r)
      OP_STEER: begin
        md_a        = centered(steer_r);
        md_b        = OPW'(1);
        md_req.dsel = DIV_5;
      end
      OP_FWD: begin
        md_a        = centered(fwd_raw_r);
        md_b        = OPW'(1);
        md_req.dsel = DIV_5;
      end
      OP_THR: begin
        md_a        = (thr_r < RAW_WIDTH'(LINK_MIN)) ? '0 : centered(thr_r);
        md_b        = OPW'(1);
        md_req.dsel = DIV_10;
      end
      OP_SW: begin
        md_a        = centered(sw_r);
        md_b        = OPW'(1);
        md_req.dsel = DIV_10;
      end
      OP_MAG: begin
        md_a        = c3_r;
        md_b        = OPW'(MAG_SCALE);
        md_req.dsel = DIV_100;
      end
      OP_FWDMIX: begin
        md_a        = c2_r;
        md_b        = mag_r;
        md_req.dsel = DIV_100;
      end
      OP_TURN: begin
        md_a        = steer_q_r;
        md_b        = mag_r;
        md_req.dsel = DIV_100;
      end
      default: begin
        md_a        = '0;
        md_b        = '0;
        md_req.dsel = DIV_5;
      end
    endcase
  end

  rcd_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (md_a),
    .op_b  (md_b),
    .done  (md_done),
    .q     (md_q)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_ISSUE;
          op_nxt    = OP_STEER;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (md_done) begin
          if (op_r == OP_TURN) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_ISSUE;
            op_nxt    = op_r + 3'd1;
          end
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_STEER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture and mapped results
  always_ff @(posedge clk) begin
    if (accept) begin
      steer_r   <= in_steer_raw;
      fwd_raw_r <= in_forward_raw;
      thr_r     <= in_throttle_raw;
      sw_r      <= in_switch_raw;
      pulse_r   <= in_intake_pulse_us;
      step_r    <= in_step_ms;
    end
    if (state_r == S_WAIT && md_done) begin
      case (op_r)
        OP_STEER: steer_q_r <= signed'(md_q[OPW-1:0]);
        OP_FWD: begin
          if (fwd_raw_r < RAW_WIDTH'(LINK_MIN)) begin
            c2_r <= '0;
          end else begin
            c2_r <= signed'(md_q[OPW-1:0]) - OPW'(CHAN_OFFSET);
          end
        end
        OP_THR:    c3_r <= signed'(md_q[OPW-1:0]);
        OP_SW:     sw_on_r <= (sw_r >= RAW_WIDTH'(LINK_MIN)) && (md_q > QW'(SWITCH_ON_MIN));
        OP_MAG:    mag_r <= signed'(md_q[OPW-1:0]);
        OP_FWDMIX: fwd_r <= md_q;
        OP_TURN:   turn_r <= md_q - QW'(mag_r);
        default: begin
        end
      endcase
    end
  end

  // mix, shaping and intake selection
  assign left_sum  = SW'(fwd_r) + SW'(turn_r);
  assign right_sum = SW'(fwd_r) - SW'(turn_r);

  rcd_shape u_shape_left (
    .val      (left_sum),
    .deadband (deadband_r),
    .cmd      (left_shaped)
  );

  rcd_shape u_shape_right (
    .val      (right_sum),
    .deadband (deadband_r),
    .cmd      (right_shaped)
  );

  assign drive_clamped = (drive_cmd_r < -CMD_W'(CMD_LIMIT)) ? -CMD_W'(CMD_LIMIT) : drive_cmd_r;

  always_comb begin
    if (pulse_r > PULSE_W'(PULSE_MAX) || pulse_r < PULSE_W'(PULSE_LOW_MIN)) begin
      intake_sel = '0;
    end else if (pulse_r < PULSE_W'(PULSE_HIGH_MIN)) begin
      intake_sel = intake_low_r;
    end else begin
      intake_sel = intake_high_r;
    end
  end

  // tick state update
  assign el_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(step_r);
  assign link   = (steer_r >= RAW_WIDTH'(LINK_MIN));

  always_comb begin
    el          = elapsed_r;
    mode_nxt    = mode_r;
    stage_nxt   = stage_r;
    right_nxt   = right_r;
    left_nxt    = left_r;
    intake_nxt  = intake_r;
    link_nxt    = link;
    manual      = 1'b0;
    auto_go     = 1'b0;
    auto_branch = 1'b0;
    if (mode_r) begin
      el = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
    end
    if (!link) begin
      right_nxt = '0;
      left_nxt  = '0;
    end else begin
      if (!mode_r && sw_on_r) begin
        mode_nxt  = 1'b1;
        el        = '0;
        stage_nxt = STG_DRIVE;
      end else if (mode_r && !sw_on_r) begin
        mode_nxt = 1'b0;
      end
      if (!mode_nxt) begin
        manual = 1'b1;
      end else begin
        auto_branch = 1'b1;
        if (el > timeout_r) begin
          stage_nxt = STG_DONE;
        end
        if (stage_nxt == STG_DRIVE) begin
          if (el < drive_ms_r) begin
            right_nxt = drive_clamped;
            auto_go   = 1'b1;
          end else begin
            stage_nxt = STG_DONE;
          end
        end
        if (!auto_go) begin
          mode_nxt = 1'b0;
          manual   = 1'b1;
        end
      end
      if (manual) begin
        left_nxt   = left_shaped;
        right_nxt  = right_shaped;
        intake_nxt = intake_sel;
      end
      if (auto_branch) begin
        intake_nxt = '0;
      end
    end
    elapsed_nxt = el;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      stage_r   <= STG_IDLE;
      elapsed_r <= '0;
      right_r   <= '0;
      left_r    <= '0;
      intake_r  <= '0;
      link_r    <= 1'b0;
    end else if (commit) begin
      mode_r    <= mode_nxt;
      stage_r   <= stage_nxt;
      elapsed_r <= elapsed_nxt;
      right_r   <= right_nxt;
      left_r    <= left_nxt;
      intake_r  <= intake_nxt;
      link_r    <= link_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= ELAPSED_W'(60000);
      drive_ms_r    <= ELAPSED_W'(2000);
      drive_cmd_r   <= CMD_W'(60);
      intake_low_r  <= PWM_W'(64);
      intake_high_r <= PWM_W'(128);
      deadband_r    <= DB_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_TIMEOUT: timeout_r     <= cfg_wdata[ELAPSED_W-1:0];
        REG_AUTO_DRIVE:   drive_ms_r    <= cfg_wdata[ELAPSED_W-1:0];
        REG_DRIVE_CMD:    drive_cmd_r   <= signed'(cfg_wdata[CMD_W-1:0]);
        REG_INTAKE_LOW:   intake_low_r  <= cfg_wdata[PWM_W-1:0];
        REG_INTAKE_HIGH:  intake_high_r <= cfg_wdata[PWM_W-1:0];
        REG_DEADBAND:     deadband_r    <= cfg_wdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_right_cmd   = right_r;
  assign out_left_cmd    = left_r;
  assign out_intake_pwm  = intake_r;
  assign out_auto_active = mode_r;
  assign out_link_ok     = link_r;

endmodule

`default_nettype wire

@@ design/rcd_muldiv.sv @@
// shared multiply then divide-by-constant unit, truncating toward zero
`default_nettype none

module rcd_muldiv
  import rcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mdu_req_t              req,
  input  wire logic signed [OPW-1:0] op_a,
  input  wire logic signed [OPW-1:0] op_b,
  output logic                       done,
  output logic signed [QW-1:0]       q
);

  localparam logic [31:0] RECIP_5   = 32'd858993459;
  localparam logic [31:0] RECIP_10  = 32'd429496729;
  localparam logic [31:0] RECIP_100 = 32'd42949672;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RCP  = 3'b010,
    MD_COR  = 3'b100
  } md_state_t;

  md_state_t   state_r, state_nxt;
  logic        done_r;
  logic [31:0] prod_r;
  logic [31:0] q0_r;
  logic        neg_r;
  div_sel_t    dsel_r;
  logic signed [QW-1:0] q_r;

  logic [OPW-1:0] mag_a, mag_b;
  logic [31:0]    mul_x, mul_y;
  logic [63:0]    mul_p;
  logic [31:0]    recip;
  logic [31:0]    qd;
  logic [31:0]    divisor;
  logic [31:0]    rem;
  logic [31:0]    q_mag;

  assign mag_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
  assign mag_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);

  always_comb begin
    case (dsel_r)
      DIV_5: begin
        recip   = RECIP_5;
        qd      = (q0_r << 2) + q0_r;
        divisor = 32'd5;
      end
      DIV_10: begin
        recip   = RECIP_10;
        qd      = (q0_r << 3) + (q0_r << 1);
        divisor = 32'd10;
      end
      DIV_100: begin
        recip   = RECIP_100;
        qd      = (q0_r << 6) + (q0_r << 5) + (q0_r << 2);
        divisor = 32'd100;
      end
      default: begin
        recip   = RECIP_5;
        qd      = (q0_r << 2) + q0_r;
        divisor = 32'd5;
      end
    endcase
  end

  // one multiplier: operand magnitudes first, then the reciprocal
  always_comb begin
    if (state_r == MD_RCP) begin
      mul_x = prod_r;
      mul_y = recip;
    end else begin
      mul_x = 32'(mag_a);
      mul_y = 32'(mag_b);
    end
  end

  assign mul_p = mul_x * mul_y;
  assign rem   = prod_r - qd;
  assign q_mag = q0_r + ((rem >= divisor) ? 32'd1 : 32'd0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          state_nxt = MD_RCP;
        end
      end
      MD_RCP:  state_nxt = MD_COR;
      MD_COR:  state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == MD_COR);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MD_IDLE && req.start) begin
      prod_r <= mul_p[31:0];
      neg_r  <= op_a[OPW-1] ^ op_b[OPW-1];
      dsel_r <= req.dsel;
    end
    if (state_r == MD_RCP) begin
      q0_r <= mul_p[63:32];
    end
    if (state_r == MD_COR) begin
      q_r <= neg_r ? -signed'(q_mag[QW-1:0]) : signed'(q_mag[QW-1:0]);
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

@@ design/rcd_shape.sv @@
// side command shaping: clamp to the command range, then deadband
`default_nettype none

module rcd_shape
  import rcd_pkg::*;
(
  input  wire logic signed [SW-1:0] val,
  input  wire logic [DB_W-1:0]      deadband,
  output logic signed [CMD_W-1:0]   cmd
);

  localparam logic signed [SW-1:0] VAL_MAX = SW'(CMD_LIMIT);
  localparam logic signed [SW-1:0] VAL_MIN = -SW'(CMD_LIMIT);

  logic signed [CMD_W-1:0] clamped;
  logic [CMD_W-1:0]        mag;

  always_comb begin
    if (val > VAL_MAX) begin
      clamped = CMD_W'(CMD_LIMIT);
    end else if (val < VAL_MIN) begin
      clamped = -CMD_W'(CMD_LIMIT);
    end else begin
      clamped = val[CMD_W-1:0];
    end
  end

  assign mag = clamped[CMD_W-1] ? CMD_W'(-clamped) : CMD_W'(clamped);
  assign cmd = (mag < CMD_W'(deadband)) ? '0 : clamped;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for the rc drive mode controller: predicted drive holds vs dut results
`default_nettype none

module tb
  import rcd_pkg::*;
();

  localparam int RAW_W = 12;
  localparam int RAW_LO = 1000;
  localparam int RAW_HI = 2000;
  localparam int ELAPSED_MAX = (1 << ELAPSED_W) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {ST_IDLE, ST_DRIVE, ST_DONE} auto_stage_t;
  typedef enum int {SEG_NOISE, SEG_MANUAL, SEG_AUTO, SEG_AUTO_HOLD} seg_kind_t;

  typedef struct packed {
    logic [RAW_W-1:0]   steer;
    logic [RAW_W-1:0]   forward;
    logic [RAW_W-1:0]   throttle;
    logic [RAW_W-1:0]   sw_raw;
    logic [PULSE_W-1:0] pulse_us;
    logic [STEP_W-1:0]  step_ms;
  } tick_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] right;
    logic signed [CMD_W-1:0] left;
    logic [PWM_W-1:0]        pwm;
    logic                    auto_on;
    logic                    link;
  } drive_out_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0]    timeout_ms;
    logic [ELAPSED_W-1:0]    drive_ms;
    logic signed [CMD_W-1:0] drive_cmd;
    logic [PWM_W-1:0]        speed_low;
    logic [PWM_W-1:0]        speed_high;
    logic [DB_W-1:0]         deadband;
  } cfg_set_t;

  class drive_scoreboard;
    logic [ELAPSED_W-1:0]    timeout_ms;
    logic [ELAPSED_W-1:0]    drive_ms;
    logic signed [CMD_W-1:0] drive_cmd;
    logic [PWM_W-1:0]        speed_low;
    logic [PWM_W-1:0]        speed_high;
    logic [DB_W-1:0]         deadband;
    bit                      auto_mode;
    auto_stage_t             stage;
    int                      elapsed_ms;
    logic signed [CMD_W-1:0] right_hold;
    logic signed [CMD_W-1:0] left_hold;
    logic [PWM_W-1:0]        intake_hold;
    drive_out_t              expected_cmds[$];
    int                      mismatches;
    int                      checked;

    function new();
      timeout_ms = 60000;
      drive_ms = 2000;
      drive_cmd = 60;
      speed_low = 64;
      speed_high = 128;
      deadband = 3;
      auto_mode = 0;
      stage = ST_IDLE;
      elapsed_ms = 0;
      right_hold = 0;
      left_hold = 0;
      intake_hold = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_AUTO_TIMEOUT: timeout_ms = data[ELAPSED_W-1:0];
        REG_AUTO_DRIVE:   drive_ms = data[ELAPSED_W-1:0];
        REG_DRIVE_CMD:    drive_cmd = data[CMD_W-1:0];
        REG_INTAKE_LOW:   speed_low = data[PWM_W-1:0];
        REG_INTAKE_HIGH:  speed_high = data[PWM_W-1:0];
        REG_DEADBAND:     deadband = data[DB_W-1:0];
        default: ;
      endcase
    endfunction

    function longint scale(longint x, longint in_lo, longint in_hi, longint out_lo,
                           longint out_hi);
      return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    endfunction

    function longint map_channel(logic [RAW_W-1:0] raw, longint lo, longint hi);
      if (raw < LINK_MIN) return 0;
      return scale(longint'(raw), RAW_LO, RAW_HI, lo, hi);
    endfunction

    function longint clamp(longint v);
      if (v > CMD_LIMIT) return CMD_LIMIT;
      if (v < -CMD_LIMIT) return -CMD_LIMIT;
      return v;
    endfunction

    function logic signed [CMD_W-1:0] side_cmd(longint v);
      longint c;
      longint m;
      c = clamp(v);
      m = (c < 0) ? -c : c;
      if (m < longint'(deadband)) c = 0;
      return CMD_W'(c);
    endfunction

    function void mix_manual(tick_t t);
      longint steer_c, fwd_c, thr_c, mag, fwd, turn;
      steer_c = map_channel(t.steer, -100, 100);
      fwd_c = map_channel(t.forward, -100, 100);
      thr_c = map_channel(t.throttle, 0, 100);
      mag = scale(thr_c, 0, 100, 0, MAG_SCALE);
      fwd = scale((fwd_c < 0) ? -fwd_c : fwd_c, 0, 100, 0, mag);
      if (fwd_c < 0) fwd = -fwd;
      turn = scale(steer_c, -100, 100, -mag, mag);
      left_hold = side_cmd(fwd + turn);
      right_hold = side_cmd(fwd - turn);
      if (t.pulse_us == 0 || t.pulse_us > PULSE_MAX || t.pulse_us < PULSE_LOW_MIN)
        intake_hold = 0;
      else if (t.pulse_us < PULSE_HIGH_MIN)
        intake_hold = speed_low;
      else
        intake_hold = speed_high;
    endfunction

    function void note_tick(tick_t t);
      bit link;
      bit sw_on;
      bit done;
      link = (t.steer >= LINK_MIN);
      if (auto_mode) begin
        elapsed_ms = elapsed_ms + int'(t.step_ms);
        if (elapsed_ms > ELAPSED_MAX) elapsed_ms = ELAPSED_MAX;
      end
      if (!link) begin
        right_hold = 0;
        left_hold = 0;
      end else begin
        sw_on = (map_channel(t.sw_raw, 0, 100) > SWITCH_ON_MIN);
        if (!auto_mode && sw_on) begin
          auto_mode = 1;
          elapsed_ms = 0;
          stage = ST_DRIVE;
        end else if (auto_mode && !sw_on) begin
          auto_mode = 0;
        end
        if (!auto_mode) begin
          mix_manual(t);
        end else begin
          done = 1;
          if (elapsed_ms > int'(timeout_ms)) stage = ST_DONE;
          if (stage == ST_DRIVE) begin
            if (elapsed_ms < int'(drive_ms)) begin
              right_hold = CMD_W'(clamp(longint'(drive_cmd)));
              done = 0;
            end else begin
              stage = ST_DONE;
            end
          end
          if (done) begin
            auto_mode = 0;
            mix_manual(t);
          end
          intake_hold = 0;
        end
      end
      expected_cmds.push_back(drive_out_t'({right_hold, left_hold, intake_hold,
                                             auto_mode, link}));
    endfunction

    function void check_result(drive_out_t got);
      drive_out_t exp_out;
      checked++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d: right %0d left %0d pwm %0d auto %0b link %0b",
                   checked, got.right, got.left, got.pwm, got.auto_on, got.link);
        return;
      end
      exp_out = expected_cmds.pop_front();
      if (got.right !== exp_out.right || got.left !== exp_out.left ||
          got.pwm !== exp_out.pwm || got.auto_on !== exp_out.auto_on ||
          got.link !== exp_out.link) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: expected right %0d left %0d pwm %0d auto %0b link %0b, %s",
                   checked, exp_out.right, exp_out.left, exp_out.pwm, exp_out.auto_on,
                   exp_out.link,
                   $sformatf("got right %0d left %0d pwm %0d auto %0b link %0b",
                             got.right, got.left, got.pwm, got.auto_on, got.link));
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [RAW_W-1:0]       in_steer_raw = '0;
  logic [RAW_W-1:0]       in_forward_raw = '0;
  logic [RAW_W-1:0]       in_throttle_raw = '0;
  logic [RAW_W-1:0]       in_switch_raw = '0;
  logic [PULSE_W-1:0]     in_intake_pulse_us = '0;
  logic [STEP_W-1:0]      in_step_ms = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CMD_W-1:0] out_right_cmd;
  logic signed [CMD_W-1:0] out_left_cmd;
  logic [PWM_W-1:0]       out_intake_pwm;
  logic                   out_auto_active;
  logic                   out_link_ok;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;
  drive_scoreboard sb;

  rc_drive_mode_controller_top #(
    .RAW_WIDTH(RAW_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_steer_raw(in_steer_raw),
    .in_forward_raw(in_forward_raw),
    .in_throttle_raw(in_throttle_raw),
    .in_switch_raw(in_switch_raw),
    .in_intake_pulse_us(in_intake_pulse_us),
    .in_step_ms(in_step_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_right_cmd(out_right_cmd),
    .out_left_cmd(out_left_cmd),
    .out_intake_pwm(out_intake_pwm),
    .out_auto_active(out_auto_active),
    .out_link_ok(out_link_ok),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_t mk(int steer, int fwd, int thr, int swr, int pulse, int stp);
    tick_t t;
    t.steer = RAW_W'(steer);
    t.forward = RAW_W'(fwd);
    t.throttle = RAW_W'(thr);
    t.sw_raw = RAW_W'(swr);
    t.pulse_us = PULSE_W'(pulse);
    t.step_ms = STEP_W'(stp);
    return t;
  endfunction

  function automatic cfg_set_t mk_cfg(int tmo, int drv, int cmd, int lo, int hi, int db);
    cfg_set_t c;
    c.timeout_ms = ELAPSED_W'(tmo);
    c.drive_ms = ELAPSED_W'(drv);
    c.drive_cmd = CMD_W'(cmd);
    c.speed_low = PWM_W'(lo);
    c.speed_high = PWM_W'(hi);
    c.deadband = DB_W'(db);
    return c;
  endfunction

  function automatic cfg_set_t random_cfg();
    int tmo, drv;
    tmo = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ELAPSED_MAX) : $urandom_range(0, 8000);
    drv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ELAPSED_MAX) : $urandom_range(0, 8000);
    return mk_cfg(tmo, drv, int'($urandom_range(0, 254)) - 127, $urandom_range(0, 255),
                  $urandom_range(0, 255),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12));
  endfunction

  function automatic logic [RAW_W-1:0] chan_value();
    if ($urandom_range(0, 5) == 0) return RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
    return RAW_W'($urandom_range(950, 2050));
  endfunction

  function automatic tick_t make_tick(seg_kind_t kind, int step_hi);
    tick_t t;
    t.steer = ($urandom_range(0, 11) == 0) ? RAW_W'($urandom_range(0, 120)) : chan_value();
    t.forward = chan_value();
    t.throttle = chan_value();
    case (kind)
      SEG_AUTO_HOLD: t.sw_raw = RAW_W'($urandom_range(1510, 2100));
      SEG_AUTO: t.sw_raw = ($urandom_range(0, 7) == 0) ? chan_value()
                                                        : RAW_W'($urandom_range(1505, 2100));
      SEG_MANUAL: t.sw_raw = RAW_W'($urandom_range(0, 1515));
      default: t.sw_raw = RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
    endcase
    case ($urandom_range(0, 3))
      0: t.pulse_us = '0;
      1: t.pulse_us = PULSE_W'($urandom_range(0, PULSE_MAX));
      default: t.pulse_us = PULSE_W'($urandom_range(1100, 1700));
    endcase
    t.step_ms = STEP_W'($urandom_range(0, step_hi));
    if (kind == SEG_NOISE) begin
      t.steer = RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
      t.forward = RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
      t.throttle = RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
      t.step_ms = STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
    end
    return t;
  endfunction

  task automatic send_tick(tick_t t, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_steer_raw <= t.steer;
    in_forward_raw <= t.forward;
    in_throttle_raw <= t.throttle;
    in_switch_raw <= t.sw_raw;
    in_intake_pulse_us <= t.pulse_us;
    in_step_ms <= t.step_ms;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_segment(seg_kind_t kind, int len, int step_hi, bit gaps);
    for (int k = 0; k < len; k++) send_tick(make_tick(kind, step_hi), gaps);
  endtask

  task automatic run_random(int count, bit gaps);
    int sent, len, step_hi;
    seg_kind_t kind;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: kind = SEG_NOISE;
        3, 4: kind = SEG_MANUAL;
        default: kind = SEG_AUTO;
      endcase
      case ($urandom_range(0, 2))
        0: step_hi = 20;
        1: step_hi = 300;
        default: step_hi = (1 << STEP_W) - 1;
      endcase
      len = $urandom_range(1, 30);
      if (len > count - sent) len = count - sent;
      send_segment(kind, len, step_hi, gaps);
      sent += len;
    end
    wait_idle();
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(cfg_set_t c);
    put_reg(REG_AUTO_TIMEOUT, CFG_DATA_W'(c.timeout_ms));
    put_reg(REG_AUTO_DRIVE, CFG_DATA_W'(c.drive_ms));
    put_reg(REG_DRIVE_CMD, CFG_DATA_W'(c.drive_cmd[CMD_W-1:0]));
    put_reg(REG_INTAKE_LOW, CFG_DATA_W'(c.speed_low));
    put_reg(REG_INTAKE_HIGH, CFG_DATA_W'(c.speed_high));
    put_reg(REG_DEADBAND, CFG_DATA_W'(c.deadband));
    cfg_we <= 1'b0;
  endtask

  // result side stall pattern
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(drive_out_t'({out_right_cmd, out_left_cmd, out_intake_pwm,
                                    out_auto_active, out_link_ok}));
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : main_seq
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, directed corners
    send_tick(mk(0, 0, 0, 0, 0, 0), 1'b1);
    send_tick(mk(99, 1500, 1500, 1000, 1500, 7), 1'b1);
    send_tick(mk(100, 1000, 1000, 1000, 1199, 0), 1'b1);
    send_tick(mk(1500, 2000, 2000, 0, 1200, 1), 1'b1);
    send_tick(mk(1500, 1000, 2000, 99, 1599, 2), 1'b1);
    send_tick(mk(4095, 4095, 4095, 1509, 1600, 1023), 1'b1);
    send_tick(mk(1500, 1510, 1500, 1200, 25000, 3), 1'b1);
    send_tick(mk(2000, 1500, 2000, 1000, 1600, 10), 1'b1);
    send_tick(mk(1000, 1000, 2000, 1000, 1300, 10), 1'b1);
    send_tick(mk(1000, 2000, 1500, 1000, 24999, 10), 1'b0);
    send_tick(mk(1500, 0, 0, 1000, 1700, 0), 1'b0);
    // auto entry, drive stage, lost link, drive end, re-entry, exit
    send_tick(mk(1500, 1500, 1500, 1510, 1700, 1023), 1'b0);
    send_tick(mk(1500, 1500, 1500, 2000, 1700, 1023), 1'b0);
    send_tick(mk(50, 1500, 1500, 2000, 1700, 1023), 1'b0);
    send_tick(mk(1500, 1800, 1800, 2000, 1700, 0), 1'b0);
    send_tick(mk(1500, 1800, 1800, 2000, 1700, 5), 1'b0);
    send_tick(mk(1500, 1200, 1800, 1000, 1700, 100), 1'b1);
    send_tick(mk(1500, 1500, 1500, 4095, 16384, 512), 1'b1);
    send_tick(mk(1500, 1500, 1500, 0, 8191, 1023), 1'b1);
    wait_idle();
    run_random(160, 1'b1);

    load_config(mk_cfg(0, 0, -127, 0, 255, 0));
    run_random(150, 1'b1);

    // long receiver hold with items offered, then saturating auto run
    load_config(mk_cfg(ELAPSED_MAX, ELAPSED_MAX, 127, 255, 0, 127));
    hold_req = 1'b1;
    run_random(60, 1'b1);
    send_segment(SEG_AUTO_HOLD, 140, (1 << STEP_W) - 1, 1'b1);
    wait_idle();

    // timeout shorter than drive stage
    load_config(mk_cfg(300, 5000, -90, 17, 200, 10));
    run_random(150, 1'b1);

    repeat (4) begin
      load_config(random_cfg());
      run_random(130, 1'b1);
    end

    load_config(mk_cfg(60000, 2000, 60, 64, 128, 3));
    rx_idle_en = 1'b0;
    run_random(180, 1'b0);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
